// File: src/wmc_pkg.sv
// wmc_pkg: shared widths, thresholds and types of the window movement classifier
`timescale 1ns / 1ps

package wmc_pkg;

    // window size and derived widths
    localparam int WINDOW_SAMPLES = 16;
    localparam int LOG_N          = $clog2(WINDOW_SAMPLES);
    localparam int CNT_W          = LOG_N;

    localparam int ACC_W  = 16;
    localparam int P_IN_W = 23;
    localparam int MOVE_W = 3;

    localparam int SZ_W = ACC_W + LOG_N;
    localparam int SQ_W = 2 * ACC_W - 1 + LOG_N;
    localparam int P_W  = P_IN_W + LOG_N;
    localparam int D_W  = 2 * ACC_W + 2 * LOG_N;
    localparam int DP_W = P_W + 1;

    localparam int S_TDATA_W = ((3 * ACC_W + 2 * P_IN_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((MOVE_W + 7) / 8) * 8;

    // window queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // scale factors: ns = N*4096, kv = N*(N-1)*4096*4096
    localparam longint NS = longint'(WINDOW_SAMPLES) * 4096;
    localparam longint KV = longint'(WINDOW_SAMPLES) * longint'(WINDOW_SAMPLES - 1)
                            * 4096 * 4096;

    // variance limits on d = N*sum_z2 - sum_z^2
    localparam longint D_LIFT_LO = (KV + 3999) / 4000;
    localparam longint D_LIFT_HI = (6 * KV) / 1000;
    localparam longint D_UP      = (85 * KV) / 1000;
    localparam longint D_DN      = (95 * KV) / 1000;

    // pressure change limits on the sum difference
    localparam longint DP_LIFT = (47 * NS) / 1000;
    localparam longint DP_UP   = (17 * NS) / 1000;
    localparam longint DP_DN   = (18 * NS) / 1000;

    // mean bands on the magnitude of the axis sums
    localparam longint X_LO    = (7 * NS) / 100;
    localparam longint X_UP_HI = (35 * NS + 99) / 100;
    localparam longint X_DN_HI = (30 * NS + 99) / 100;
    localparam longint Y_LO    = (65 * NS) / 1000;
    localparam longint Y_HI    = (25 * NS + 99) / 100;

    typedef enum logic [MOVE_W-1:0] {
        MOVE_IDLE        = 3'd0,
        MOVE_LIFT_UP     = 3'd1,
        MOVE_LIFT_DOWN   = 3'd2,
        MOVE_STAIRS_UP   = 3'd3,
        MOVE_STAIRS_DOWN = 3'd4
    } movement_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SQUARE,
        BK_DIFF,
        BK_DECIDE
    } back_state_t;

    // sums of one full window
    typedef struct packed {
        logic signed [SZ_W-1:0] sum_x;
        logic signed [SZ_W-1:0] sum_y;
        logic signed [SZ_W-1:0] sum_z;
        logic        [SQ_W-1:0] sum_z_squared;
        logic        [P_W-1:0]  sum_p_now;
        logic        [P_W-1:0]  sum_p_before;
    } window_sum_t;

endpackage

// File: src/wmc_front.sv
// wmc_front: takes samples and accumulates the window sums
`timescale 1ns / 1ps

module wmc_front
    import wmc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 push_valid,
    input  logic                 push_ready,
    output window_sum_t          push_data
);

    logic                    busy_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic signed [ACC_W-1:0] ax_reg;
    logic signed [ACC_W-1:0] ay_reg;
    logic signed [ACC_W-1:0] az_reg;
    logic [P_IN_W-1:0]       pn_reg;
    logic [P_IN_W-1:0]       pb_reg;
    window_sum_t             sums_reg;
    window_sum_t             sums_next;
    logic [31:0]             z_sq;
    logic                    last_sample;
    logic                    do_accept;
    logic                    do_advance;

    assign s_tready    = !busy_reg;
    assign do_accept   = s_tvalid && s_tready;
    assign last_sample = (cnt_reg == CNT_W'(WINDOW_SAMPLES - 1));
    assign do_advance  = busy_reg && (!last_sample || push_ready);

    // square of z, nonnegative and below 2^31
    assign z_sq = 32'(az_reg) * 32'(az_reg);

    // running sums including the held sample
    always_comb
    begin
        sums_next.sum_x         = sums_reg.sum_x + SZ_W'(ax_reg);
        sums_next.sum_y         = sums_reg.sum_y + SZ_W'(ay_reg);
        sums_next.sum_z         = sums_reg.sum_z + SZ_W'(az_reg);
        sums_next.sum_z_squared = sums_reg.sum_z_squared + SQ_W'(z_sq);
        sums_next.sum_p_now     = sums_reg.sum_p_now + P_W'(pn_reg);
        sums_next.sum_p_before  = sums_reg.sum_p_before + P_W'(pb_reg);
    end

    // the full window goes to the queue with the last sample folded in
    assign push_valid = busy_reg && last_sample;
    assign push_data  = sums_next;

    // sample holding register
    always_ff @(posedge clk)
    begin
        if (do_accept)
        begin
            ax_reg <= s_tdata[ACC_W-1:0];
            ay_reg <= s_tdata[2*ACC_W-1:ACC_W];
            az_reg <= s_tdata[3*ACC_W-1:2*ACC_W];
            pn_reg <= s_tdata[3*ACC_W+P_IN_W-1:3*ACC_W];
            pb_reg <= s_tdata[3*ACC_W+2*P_IN_W-1:3*ACC_W+P_IN_W];
        end
    end

    // busy flag, sample count and sums
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            sums_reg <= '0;
        end
        else
        begin
            if (do_accept)
            begin
                busy_reg <= 1'b1;
            end
            else if (do_advance)
            begin
                busy_reg <= 1'b0;
            end
            if (do_advance)
            begin
                if (last_sample)
                begin
                    cnt_reg  <= '0;
                    sums_reg <= '0;
                end
                else
                begin
                    cnt_reg  <= cnt_reg + 1'b1;
                    sums_reg <= sums_next;
                end
            end
        end
    end

    // a sample that is not the last is accumulated without a stall
    assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && !last_sample |=> !busy_reg)
        else $error("front: sample not accumulated in one cycle");

    // a pushed window restarts the count
    assert property (@(posedge clk) disable iff (!rst_n)
        push_valid && push_ready |=> cnt_reg == '0 && sums_reg == '0)
        else $error("front: window not cleared after push");

endmodule

// File: src/wmc_queue.sv
// wmc_queue: short queue of window sums between front and back
`timescale 1ns / 1ps

module wmc_queue
    import wmc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push_valid,
    output logic        push_ready,
    input  window_sum_t push_data,
    output logic        pop_valid,
    input  logic        pop_ready,
    output window_sum_t pop_data
);

    window_sum_t       entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] cnt_reg;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (cnt_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_data   = entry_reg[rd_ptr_reg];

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                              : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                              : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    // empty or full queue has both pointers on the same entry
    assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == '0 || cnt_reg == QCNT_W'(QUEUE_DEPTH)) |-> wr_ptr_reg == rd_ptr_reg)
        else $error("queue: pointers disagree with fill count");

    // a lone push grows the count by one
    assert property (@(posedge clk) disable iff (!rst_n)
        do_push && !do_pop |=> cnt_reg == $past(cnt_reg) + 1'b1)
        else $error("queue: push lost");

endmodule

// File: src/wmc_back.sv
// wmc_back: classifies one window of sums and holds the result
`timescale 1ns / 1ps

module wmc_back
    import wmc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 pop_valid,
    output logic                 pop_ready,
    input  window_sum_t          pop_data,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata
);

    back_state_t            state_reg;
    back_state_t            state_next;
    window_sum_t            win_reg;
    logic [D_W-1:0]         szsq_reg;
    logic [D_W-1:0]         nszz_reg;
    logic [SZ_W-1:0]        ax_reg;
    logic [SZ_W-1:0]        ay_reg;
    logic signed [DP_W-1:0] dp_reg;
    logic signed [D_W-1:0]  d_reg;
    movement_t              move_reg;
    movement_t              move_next;
    logic                   out_valid_reg;
    logic                   ld_win;
    logic                   ld_sq;
    logic                   ld_d;
    logic                   out_load;
    logic                   out_free;
    logic signed [63:0]     d64;
    logic signed [63:0]     dp64;
    logic signed [63:0]     ax64;
    logic signed [63:0]     ay64;
    logic                   var_small;
    logic                   y_band;
    logic                   x_up;
    logic                   x_down;

    assign out_free = !out_valid_reg || m_tready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (pop_valid)
                begin
                    state_next = BK_SQUARE;
                end
            end
            BK_SQUARE: state_next = BK_DIFF;
            BK_DIFF:   state_next = BK_DECIDE;
            BK_DECIDE:
            begin
                if (out_free)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:   state_next = BK_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        pop_ready = 1'b0;
        ld_win    = 1'b0;
        ld_sq     = 1'b0;
        ld_d      = 1'b0;
        out_load  = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                pop_ready = 1'b1;
                ld_win    = pop_valid;
            end
            BK_SQUARE: ld_sq    = 1'b1;
            BK_DIFF:   ld_d     = 1'b1;
            BK_DECIDE: out_load = out_free;
            default:   pop_ready = 1'b0;
        endcase
    end

    // squares, magnitudes and pressure change, then the variance term
    always_ff @(posedge clk)
    begin
        if (ld_win)
        begin
            win_reg <= pop_data;
        end
        if (ld_sq)
        begin
            szsq_reg <= win_reg.sum_z * win_reg.sum_z;
            nszz_reg <= D_W'(win_reg.sum_z_squared) * D_W'(WINDOW_SAMPLES);
            ax_reg   <= win_reg.sum_x[SZ_W-1] ? SZ_W'(-win_reg.sum_x) : SZ_W'(win_reg.sum_x);
            ay_reg   <= win_reg.sum_y[SZ_W-1] ? SZ_W'(-win_reg.sum_y) : SZ_W'(win_reg.sum_y);
            dp_reg   <= $signed({1'b0, win_reg.sum_p_now})
                        - $signed({1'b0, win_reg.sum_p_before});
        end
        if (ld_d)
        begin
            d_reg <= $signed(nszz_reg - szsq_reg);
        end
        if (out_load)
        begin
            move_reg <= move_next;
        end
    end

    // threshold tests against constants scaled by the window size
    assign d64  = 64'(d_reg);
    assign dp64 = 64'(dp_reg);
    assign ax64 = 64'(ax_reg);
    assign ay64 = 64'(ay_reg);

    assign var_small = (d64 >= D_LIFT_LO) && (d64 <= D_LIFT_HI);
    assign y_band    = (ay64 > Y_LO) && (ay64 < Y_HI);
    assign x_up      = (ax64 > X_LO) && (ax64 < X_UP_HI);
    assign x_down    = (ax64 > X_LO) && (ax64 < X_DN_HI);

    // decisions in priority order
    always_comb
    begin
        if (var_small && (dp64 < -DP_LIFT))
        begin
            move_next = MOVE_LIFT_UP;
        end
        else if (var_small && (dp64 > DP_LIFT))
        begin
            move_next = MOVE_LIFT_DOWN;
        end
        else if ((x_up || y_band) && (d64 > D_UP) && (dp64 < -DP_UP))
        begin
            move_next = MOVE_STAIRS_UP;
        end
        else if ((x_down || y_band) && (d64 > D_DN) && (dp64 > DP_DN))
        begin
            move_next = MOVE_STAIRS_DOWN;
        end
        else
        begin
            move_next = MOVE_IDLE;
        end
    end

    // state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'(move_reg);

    // a result only appears from the decide step
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg) == BK_DECIDE)
        else $error("back: result without decision");

endmodule

// File: src/window_movement_classifier.sv
// window_movement_classifier: top level, front accumulator, window queue and classifier
//
//  channel  dir  handshake            payload
//  s_*      in   s_tvalid / s_tready  tdata: accel_x, accel_y, accel_z, pressure_now,
//                                     pressure_before
//  m_*      out  m_tvalid / m_tready  tdata: movement
//
// a sample is taken in its request cycle and held for the accumulate cycle with the z squaring,
// so the front takes no new sample before it is through with the last one
// a full window waits in the queue for an idle back, which squares, diffs and decides on it
// reset clears the sums, count, queue and result valid flag at once, no clearing pass
// the last sample of a window waits in the front while the two-entry queue is full
// the result register holds a result until taken while the back works on the next window
`timescale 1ns / 1ps

module window_movement_classifier
    import wmc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [15:0] accel_x, [31:16] accel_y, [47:32] accel_z, [70:48] pressure_now,
    // [93:71] pressure_before, [95:94] zero
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [2:0] movement, [7:3] zero
    output logic [M_TDATA_W-1:0] m_tdata
);

    logic        push_valid;
    logic        push_ready;
    window_sum_t push_data;
    logic        pop_valid;
    logic        pop_ready;
    window_sum_t pop_data;

    // sample accumulation
    wmc_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    // window queue
    wmc_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // classification
    wmc_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule
